// File: rtl/bpq_pkg.sv
// shared types, codes and helpers for the two-button press classifier queue
package bpq_pkg;

  localparam int QDEPTH = 16;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int TIME_W = 63;
  localparam int THR_W  = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000000);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PRESSED = 2'd1;
  localparam logic [1:0] KIND_LONG    = 2'd2;

  localparam logic BTN_ONE = 1'b0;
  localparam logic BTN_TWO = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [THR_W-1:0]  thr_t;
  typedef logic [1:0]        kind_t;

  typedef struct packed {
    logic  valid;
    logic  button;
    kind_t kind;
    time_t stamp;
  } push_req_t;

  typedef struct packed {
    logic  valid;
    logic  button;
    kind_t kind;
    time_t stamp;
  } head_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// File: rtl/two_button_press_classifier_queue.sv
// top level: input stage, two button classifiers, event fifo and result register
//
// Two buttons (active low) are sampled through the in_ stream; each item is
// either a sample (tuser operation 0) carrying both levels and the time, or a
// read (operation 1) that pops the oldest queued event. Press, long press and
// long release events go into a 16-entry fifo, button one first; an event that
// finds the fifo full is dropped but still flagged in events_generated.
// Every accepted item yields exactly one result on the out_ stream.
// Between input transfer and result valid lie the input register and then the
// result register. Throughput is one item per cycle while out_tready does not
// hold the result, set by the single pass of classifier compare and fifo update
// between those two registers.
// The cfg_ channel writes the long press threshold; it is always ready.
// After rst_n low both buttons read as released, the fifo is empty and the
// threshold is 1000000. When out_tready is low the result is held, the input
// register still takes one more item, and then in_tready drops.
module two_button_press_classifier_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // button_one_level, button_two_level, current_time, zero pad
  input  logic [0:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // events_generated, event_valid, event_button, event_kind,
                                  // event_time, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import bpq_pkg::*;

  logic  s1_valid_r;
  logic  s1_op_r, s1_lv1_r, s1_lv2_r;
  time_t s1_time_r;
  thr_t  thr_r;
  logic  advance, smp_en, pop;
  kind_t kind_a, kind_b;
  push_req_t push_a, push_b;
  head_t head;

  logic  out_valid_r;
  logic  gen_r, evv_r, evb_r;
  kind_t evk_r;
  time_t evt_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign smp_en    = advance && (s1_op_r == OP_SAMPLE);
  assign pop       = advance && (s1_op_r == OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser[0];
      s1_lv1_r  <= in_tdata[0];
      s1_lv2_r  <= in_tdata[1];
      s1_time_r <= in_tdata[64:2];
    end
  end

  bpq_classifier u_cls_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (smp_en),
    .level_i (s1_lv1_r),
    .now_i   (s1_time_r),
    .thr_i   (thr_r),
    .kind_o  (kind_a)
  );

  bpq_classifier u_cls_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (smp_en),
    .level_i (s1_lv2_r),
    .now_i   (s1_time_r),
    .thr_i   (thr_r),
    .kind_o  (kind_b)
  );

  always_comb begin
    push_a.valid  = smp_en && (kind_a != KIND_NONE);
    push_a.button = BTN_ONE;
    push_a.kind   = kind_a;
    push_a.stamp  = s1_time_r;
    push_b.valid  = smp_en && (kind_b != KIND_NONE);
    push_b.button = BTN_TWO;
    push_b.kind   = kind_b;
    push_b.stamp  = s1_time_r;
  end

  bpq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_a_i (push_a),
    .push_b_i (push_b),
    .pop_i    (pop),
    .head_o   (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gen_r <= 1'b0;
      evv_r <= 1'b0;
      evb_r <= 1'b0;
      evk_r <= KIND_NONE;
      evt_r <= '0;
      if (s1_op_r == OP_SAMPLE) begin
        gen_r <= (kind_a != KIND_NONE) || (kind_b != KIND_NONE);
      end else if (head.valid) begin
        evv_r <= 1'b1;
        evb_r <= head.button;
        evk_r <= head.kind;
        evt_r <= head.stamp;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, evt_r, evk_r, evb_r, evv_r, gen_r};

endmodule

// File: rtl/bpq_classifier.sv
// per-button edge and long press classifier with its own level and press state
module bpq_classifier (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en_i,
  input  logic          level_i,
  input  bpq_pkg::time_t now_i,
  input  bpq_pkg::thr_t  thr_i,
  output bpq_pkg::kind_t kind_o
);
  import bpq_pkg::*;

  logic  last_r, last_nxt;
  logic  held_r, held_nxt;
  time_t start_r, start_nxt;
  logic  changed;
  logic  is_long;
  time_t elapsed;

  assign changed = (level_i != last_r);
  assign elapsed = now_i - start_r;
  assign is_long = (start_r != '0) && (now_i >= start_r) &&
                   (elapsed > {{(TIME_W-THR_W){1'b0}}, thr_i});

  always_comb begin
    last_nxt  = last_r;
    held_nxt  = held_r;
    start_nxt = start_r;
    kind_o    = KIND_NONE;
    if (changed) begin
      if (!level_i) begin
        kind_o = KIND_PRESSED;
      end else if (is_long) begin
        kind_o = KIND_LONG;
      end
      if (en_i) begin
        last_nxt  = level_i;
        held_nxt  = !level_i;
        start_nxt = level_i ? '0 : now_i;
      end
    end else if (held_r && is_long) begin
      kind_o = KIND_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b1;
      held_r  <= 1'b0;
      start_r <= '0;
    end else begin
      last_r  <= last_nxt;
      held_r  <= held_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// File: rtl/bpq_queue.sv
// event fifo taking up to two pushes or one pop per cycle
module bpq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  bpq_pkg::push_req_t push_a_i,
  input  bpq_pkg::push_req_t push_b_i,
  input  logic               pop_i,
  output bpq_pkg::head_t     head_o
);
  import bpq_pkg::*;

  localparam cnt_t CNT_FULL = CNT_W'(QDEPTH);

  logic [2:0] tag_mem [QDEPTH];
  time_t      time_mem [QDEPTH];

  ptr_t rp_r, rp_nxt;
  ptr_t wp_r, wp_nxt;
  cnt_t count_r, count_nxt;
  cnt_t count_mid;
  logic acc_a, acc_b, do_pop;
  ptr_t addr_b;

  assign acc_a     = push_a_i.valid && (count_r < CNT_FULL);
  assign count_mid = count_r + CNT_W'(acc_a);
  assign acc_b     = push_b_i.valid && (count_mid < CNT_FULL);
  assign addr_b    = acc_a ? ptr_inc(wp_r) : wp_r;
  assign do_pop    = pop_i && (count_r != '0);

  always_comb begin
    head_o = '0;
    if (count_r != '0) begin
      head_o.valid  = 1'b1;
      head_o.button = tag_mem[rp_r][2];
      head_o.kind   = tag_mem[rp_r][1:0];
      head_o.stamp  = time_mem[rp_r];
    end
  end

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_mid + CNT_W'(acc_b);
    if (acc_b) begin
      wp_nxt = ptr_inc(addr_b);
    end else if (acc_a) begin
      wp_nxt = ptr_inc(wp_r);
    end
    if (do_pop) begin
      rp_nxt    = ptr_inc(rp_r);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_a) begin
      tag_mem[wp_r]  <= {push_a_i.button, push_a_i.kind};
      time_mem[wp_r] <= push_a_i.stamp;
    end
    if (acc_b) begin
      tag_mem[addr_b]  <= {push_b_i.button, push_b_i.kind};
      time_mem[addr_b] <= push_b_i.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rp_r == wp_r))
    else $error("empty queue with unequal pointers");

  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && (push_a_i.valid || push_b_i.valid)))
    else $error("pop and push in one cycle");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!pop_i) |=> (count_r == $past(count_mid) + CNT_W'($past(acc_b))))
    else $error("queue count does not follow pushes");

endmodule

// File: tb/tb_two_button_press_classifier_queue.sv
// testbench for the two-button press classifier queue with predicted results
`timescale 1ns / 100ps

module tb_two_button_press_classifier_queue;
  import bpq_pkg::*;

  typedef struct {
    logic  op;
    logic  lvl_one;
    logic  lvl_two;
    time_t now;
  } press_item_t;

  typedef struct {
    logic  button;
    kind_t kind;
    time_t stamp;
  } press_event_t;

  typedef struct {
    logic  generated;
    logic  found;
    logic  button;
    kind_t kind;
    time_t stamp;
  } press_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  press_item_t   pending_samples[$];
  press_result_t awaited_results[$];
  press_event_t  event_fifo[$];

  // predictor state
  thr_t  hold_limit;
  logic  btn_level[2];
  logic  btn_held[2];
  time_t btn_start[2];

  logic in_fire;
  logic out_fire;
  logic cfg_fire;
  logic tx_busy;
  int   tx_wait;
  int   tx_max_gap;
  int   rx_wait;
  int   rx_max_stall;
  int   stall_request;
  int   long_stall;
  int   fail_count;
  press_item_t   tx_item;
  press_result_t got;
  press_result_t want;

  // stimulus generator state
  logic  gen_one;
  logic  gen_two;
  time_t gen_now;

  two_button_press_classifier_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic held_long(int b, time_t now);
    if (btn_start[b] == '0 || now < btn_start[b]) return 1'b0;
    return (now - btn_start[b]) > time_t'(hold_limit);
  endfunction

  function automatic kind_t classify_button(int b, logic lvl, time_t now);
    kind_t k;
    k = KIND_NONE;
    if (lvl != btn_level[b]) begin
      btn_level[b] = lvl;
      if (lvl == 1'b0) begin
        btn_held[b]  = 1'b1;
        btn_start[b] = now;
        k = KIND_PRESSED;
      end else begin
        if (held_long(b, now)) k = KIND_LONG;
        btn_held[b]  = 1'b0;
        btn_start[b] = '0;
      end
    end else if (btn_held[b] && held_long(b, now)) begin
      k = KIND_LONG;
    end
    return k;
  endfunction

  function automatic void log_press_event(logic button, kind_t kind, time_t now);
    press_event_t ev;
    ev.button = button;
    ev.kind   = kind;
    ev.stamp  = now;
    if (event_fifo.size() < QDEPTH) event_fifo.push_back(ev);
  endfunction

  function automatic press_result_t classify_item(logic op, logic l1, logic l2, time_t now);
    press_result_t r;
    press_event_t  ev;
    kind_t         k;
    r = '{1'b0, 1'b0, 1'b0, KIND_NONE, '0};
    if (op == OP_SAMPLE) begin
      k = classify_button(0, l1, now);
      if (k != KIND_NONE) begin
        log_press_event(BTN_ONE, k, now);
        r.generated = 1'b1;
      end
      k = classify_button(1, l2, now);
      if (k != KIND_NONE) begin
        log_press_event(BTN_TWO, k, now);
        r.generated = 1'b1;
      end
    end else if (event_fifo.size() > 0) begin
      ev = event_fifo.pop_front();
      r.found  = 1'b1;
      r.button = ev.button;
      r.kind   = ev.kind;
      r.stamp  = ev.stamp;
    end
    return r;
  endfunction

  function automatic time_t rand_time();
    return time_t'({$urandom, $urandom});
  endfunction

  // monitor: transfers are sampled at the rising edge
  always @(posedge clk) begin
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (cfg_fire) hold_limit = cfg_data;
    if (in_fire)
      awaited_results.push_back(classify_item(in_tuser[0], in_tdata[0], in_tdata[1],
                                              in_tdata[64:2]));
    if (out_fire) begin
      got.generated = out_tdata[0];
      got.found     = out_tdata[1];
      got.button    = out_tdata[2];
      got.kind      = out_tdata[4:3];
      got.stamp     = out_tdata[67:5];
      if (awaited_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: gen=%0d vld=%0d btn=%0d kind=%0d time=%0h",
                   got.generated, got.found, got.button, got.kind, got.stamp);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.generated !== want.generated || got.found !== want.found ||
            got.button !== want.button || got.kind !== want.kind ||
            got.stamp !== want.stamp || out_tdata[71:68] !== 4'b0) begin
          if (fail_count < 10)
            $display({"mismatch: expected gen=%0d vld=%0d btn=%0d kind=%0d time=%0h,",
                      " got gen=%0d vld=%0d btn=%0d kind=%0d time=%0h pad=%0h"},
                     want.generated, want.found, want.button, want.kind, want.stamp,
                     got.generated, got.found, got.button, got.kind, got.stamp,
                     out_tdata[71:68]);
          fail_count++;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        tx_busy = 1'b0;
        tx_wait = $urandom_range(tx_max_gap, 0);
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_samples.size() > 0) begin
          tx_item = pending_samples.pop_front();
          in_tuser <= tx_item.op;
          in_tdata <= {7'b0, tx_item.now, tx_item.lvl_two, tx_item.lvl_one};
          tx_busy = 1'b1;
        end
      end
      in_tvalid <= tx_busy;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_request > 0) begin
        long_stall    = stall_request;
        stall_request = 0;
      end
      if (out_fire) rx_wait = $urandom_range(rx_max_stall, 0);
      if (long_stall > 0) begin
        long_stall--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_item(logic op, logic l1, logic l2, time_t now);
    press_item_t it;
    it.op      = op;
    it.lvl_one = l1;
    it.lvl_two = l2;
    it.now     = now;
    pending_samples.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || tx_busy || awaited_results.size() != 0);
  endtask

  task automatic write_threshold(thr_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int count, int read_pct, thr_t thr);
    longint unsigned span;
    longint unsigned advance;
    int r;
    span = longint'(thr) / 2 + 2;
    repeat (count) begin
      if ($urandom_range(99) < read_pct) begin
        add_item(OP_READ, 1'($urandom_range(1)), 1'($urandom_range(1)), rand_time());
      end else begin
        if ($urandom_range(3) == 0) gen_one = ~gen_one;
        if ($urandom_range(3) == 0) gen_two = ~gen_two;
        advance = {$urandom, $urandom} % span;
        r = $urandom_range(63);
        if (r == 0) gen_now = '0;
        else if (r < 3) gen_now = rand_time();
        else if (r < 5) gen_now = gen_now - time_t'(advance);
        else gen_now = gen_now + time_t'(advance);
        add_item(OP_SAMPLE, gen_one, gen_two, gen_now);
      end
    end
  endtask

  task automatic run_phase(thr_t thr, int count, int read_pct, int gap, int stall,
                           logic squeeze);
    wait_drained();
    write_threshold(thr);
    tx_max_gap   = gap;
    rx_max_stall = stall;
    if (squeeze) stall_request = 60;
    queue_random(count, read_pct, thr);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    cfg_fire = 1'b0;
    tx_busy = 1'b0;
    tx_wait = 0;
    rx_wait = 0;
    tx_max_gap = 13;
    rx_max_stall = 13;
    stall_request = 0;
    long_stall = 0;
    fail_count = 0;
    hold_limit = THR_RESET;
    btn_level = '{1'b1, 1'b1};
    btn_held = '{1'b0, 1'b0};
    btn_start = '{'0, '0};
    gen_one = 1'b1;
    gen_two = 1'b1;
    gen_now = time_t'(5);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty read, presses at time zero never turn long
    add_item(OP_READ, 1'b1, 1'b1, '1);
    add_item(OP_SAMPLE, 1'b0, 1'b0, '0);
    add_item(OP_SAMPLE, 1'b0, 1'b0, '1);
    add_item(OP_SAMPLE, 1'b1, 1'b1, '1);
    add_item(OP_READ, 1'b0, 1'b0, '0);
    add_item(OP_READ, 1'b1, 1'b0, '0);
    add_item(OP_READ, 1'b0, 1'b1, '0);
    // threshold edge, time going backwards, long release
    add_item(OP_SAMPLE, 1'b0, 1'b1, time_t'(100));
    add_item(OP_SAMPLE, 1'b0, 1'b1, time_t'(1000100));
    add_item(OP_SAMPLE, 1'b0, 1'b1, time_t'(1000101));
    add_item(OP_SAMPLE, 1'b0, 1'b1, time_t'(50));
    add_item(OP_SAMPLE, 1'b1, 1'b1, time_t'(1000200));
    // short press of button two
    add_item(OP_SAMPLE, 1'b1, 1'b0, time_t'(10));
    add_item(OP_SAMPLE, 1'b1, 1'b1, time_t'(20));
    // both held past the threshold until the queue overflows
    add_item(OP_SAMPLE, 1'b0, 1'b0, time_t'(1));
    repeat (6) add_item(OP_SAMPLE, 1'b0, 1'b0, '1);
    repeat (4) add_item(OP_READ, 1'b0, 1'b0, '1);

    run_phase(32'h0, 150, 40, 13, 13, 1'b0);
    run_phase(32'hFFFF_FFFF, 150, 30, 0, 13, 1'b0);
    run_phase(thr_t'($urandom_range(40, 1)), 150, 35, 0, 0, 1'b1);
    run_phase(thr_t'($urandom_range(5000, 41)), 150, 20, 13, 0, 1'b0);
    run_phase(thr_t'($urandom), 150, 50, 13, 13, 1'b0);
    run_phase(32'h1, 150, 70, 0, 0, 1'b0);
    run_phase(thr_t'($urandom_range(100000, 100)), 150, 40, 13, 13, 1'b1);
    run_phase(THR_RESET, 150, 30, 0, 13, 1'b0);
    run_phase(32'hFFFF_FFFE, 150, 45, 13, 0, 1'b0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (awaited_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
